// File: rtl/directional_power_swr_meter_assert.svh
// Assertion macros for the directional power and SWR meter.
// Depends on nothing; included by RTL modules that assert.
`ifndef DIRECTIONAL_POWER_SWR_METER_ASSERT_SVH
`define DIRECTIONAL_POWER_SWR_METER_ASSERT_SVH
`ifndef SYNTHESIS
`define DPSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DPSM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define DPSM_ASSERT(label, prop, msg)
`define DPSM_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// File: rtl/dpsm_pkg.sv
// Shared types and constants of the directional power and SWR meter.
// Depends on nothing.
package dpsm_pkg;
  localparam int unsigned SampleBitsDef = 10;
  localparam int signed   OffsetAdjDef  = 0;
  localparam int unsigned SumW   = 18;
  localparam int unsigned VoltW  = 20;
  localparam int unsigned PowerW = 24;
  localparam logic [17:0] SumMax = 18'h3FFFF;
  localparam logic [15:0] RhoMax = 16'hFFFF;
  localparam logic [14:0] SwrMin = 15'd256;
  localparam logic [14:0] SwrMax = 15'd25574;

  typedef enum logic [2:0] {
    RegAvg = 3'd0, RegCalFwd = 3'd1, RegCalRev = 3'd2, RegCoefA = 3'd3,
    RegCoefB = 3'd4, RegCoefC = 3'd5, RegCoefD = 3'd6, RegPowerMin = 3'd7
  } reg_idx_e;

  typedef enum logic [4:0] {
    StIdle, StVolt, StSq, StCube, StPb, StPc, StPd, StPwr, StNext,
    StCmp, StDivInit, StDiv, StSqrtInit, StSqrt, StSwrInit, StSwrDiv, StSwrFin,
    StOut
  } state_e;

  typedef struct packed {
    logic acc;       // add a pair
    logic clear;     // clear sums
    logic start_ch;  // marks the end of a channel pass; not used by the datapath
    logic sel_rev;
    logic volt;
    logic sq;
    logic cube;
    logic pa;
    logic pb;
    logic pc;
    logic pd;
    logic pwr;
    logic cmp;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic swr_init;
    logic swr_step;
    logic swr_fin;
  } cmd_t;

  typedef struct packed {
    logic group_end;
    logic valid;
    logic rho_max;
    logic iter_done;
  } status_t;
endpackage

// File: rtl/dpsm_ctrl.sv
// Sequencer of the directional power and SWR meter.
// Depends on dpsm_pkg and the assertion header.
`include "directional_power_swr_meter_assert.svh"
module dpsm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dpsm_pkg::status_t sts_i,
  output dpsm_pkg::cmd_t    cmd_o
);
  import dpsm_pkg::*;
  state_e state_q, state_d;
  logic   rev_q, rev_d;
  logic   ov_q, ov_d;

  always_comb begin
    state_d = state_q;
    rev_d = rev_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && sts_i.group_end) begin
          state_d = StVolt;
          rev_d = 1'b0;
        end
      end
      StVolt: state_d = StSq;
      StSq:   state_d = StCube;
      StCube: state_d = StPb;
      StPb:   state_d = StPc;
      StPc:   state_d = StPd;
      StPd:   state_d = StPwr;
      StPwr:  state_d = StNext;
      StNext: begin
        if (rev_q) begin
          state_d = StCmp;
        end else begin
          state_d = StVolt;
          rev_d = 1'b1;
        end
      end
      StCmp: begin
        if (!sts_i.valid) state_d = StOut;
        else if (sts_i.rho_max) state_d = StSwrInit;
        else state_d = StDivInit;
      end
      StDivInit:  state_d = StDiv;
      StDiv:      if (sts_i.iter_done) state_d = StSqrtInit;
      StSqrtInit: state_d = StSqrt;
      StSqrt:     if (sts_i.iter_done) state_d = StSwrInit;
      StSwrInit:  state_d = StSwrDiv;
      StSwrDiv:   if (sts_i.iter_done) state_d = StSwrFin;
      StSwrFin:   state_d = StOut;
      StOut:      if (!ov_q || out_ready_i) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = (state_q == StIdle);
    cmd_o.sel_rev = rev_q;
    ov_d = ov_q;
    if (out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      StIdle:     cmd_o.acc = in_valid_i;
      StVolt:     cmd_o.volt = 1'b1;
      StSq:       cmd_o.sq = 1'b1;
      StCube:     begin cmd_o.cube = 1'b1; cmd_o.pa = 1'b1; end
      StPb:       cmd_o.pb = 1'b1;
      StPc:       cmd_o.pc = 1'b1;
      StPd:       cmd_o.pd = 1'b1;
      StPwr:      cmd_o.pwr = 1'b1;
      StNext:     cmd_o.start_ch = 1'b1;
      StCmp:      cmd_o.cmp = 1'b1;
      StDivInit:  cmd_o.div_init = 1'b1;
      StDiv:      cmd_o.div_step = 1'b1;
      StSqrtInit: cmd_o.sqrt_init = 1'b1;
      StSqrt:     cmd_o.sqrt_step = 1'b1;
      StSwrInit:  cmd_o.swr_init = 1'b1;
      StSwrDiv:   cmd_o.swr_step = 1'b1;
      StSwrFin:   cmd_o.swr_fin = 1'b1;
      StOut: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          cmd_o.clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rev_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rev_q <= rev_d;
      ov_q <= ov_d;
    end
  end

  `DPSM_ASSERT_NEXT(a_out_loads, state_q == StOut && (!ov_q || out_ready_i), out_valid_o && state_q == StIdle, "result not presented")
  `DPSM_ASSERT(a_ready_idle, in_ready_o |-> state_q == StIdle, "ready outside idle")
  `DPSM_ASSERT_NEXT(a_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
endmodule

// File: rtl/dpsm_datapath.sv
// Accumulators, polynomial and ratio units of the meter.
// Depends on dpsm_pkg.
module dpsm_datapath #(
  parameter int unsigned SampleBits = dpsm_pkg::SampleBitsDef,
  parameter int signed   OffsetAdj  = dpsm_pkg::OffsetAdjDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dpsm_pkg::cmd_t        cmd_i,
  output dpsm_pkg::status_t     sts_o,
  input  logic [SampleBits-1:0] fwd_sample_i,
  input  logic [SampleBits-1:0] rev_sample_i,
  input  logic [7:0]            avg_count_i,
  input  logic [23:0]           cal_fwd_i,
  input  logic [23:0]           cal_rev_i,
  input  logic signed [23:0]    coef_a_i,
  input  logic signed [23:0]    coef_b_i,
  input  logic signed [23:0]    coef_c_i,
  input  logic signed [23:0]    coef_d_i,
  input  logic [23:0]           power_min_i,
  output logic [23:0]           fwd_power_o,
  output logic [23:0]           rev_power_o,
  output logic                  fwd_below_min_o,
  output logic                  swr_valid_o,
  output logic [15:0]           reflection_o,
  output logic [14:0]           swr_value_o
);
  import dpsm_pkg::*;
  logic [7:0]  cnt_q;
  logic [17:0] fsum_q, rsum_q;
  logic [18:0] fadd, radd;
  logic [7:0]  count, cnt_inc;
  assign count = (avg_count_i == 8'd0) ? 8'd1 : avg_count_i;
  assign cnt_inc = cnt_q + 8'd1;
  assign fadd = {1'b0, fsum_q} + 19'(fwd_sample_i);
  assign radd = {1'b0, rsum_q} + 19'(rev_sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      fsum_q <= '0;
      rsum_q <= '0;
    end else if (cmd_i.clear) begin
      cnt_q <= '0;
      fsum_q <= '0;
      rsum_q <= '0;
    end else if (cmd_i.acc) begin
      cnt_q <= cnt_inc;
      fsum_q <= fadd[18] ? SumMax : fadd[17:0];
      rsum_q <= radd[18] ? SumMax : radd[17:0];
    end
  end

  // volts
  logic signed [27:0] term;
  logic [23:0] cal;
  logic [45:0] vprod;
  logic [37:0] vsh;
  logic [19:0] v_q;
  logic [24:0] v2_q;
  logic [28:0] v3_q;
  logic signed [67:0] acc_q;
  logic [23:0] pf_q, pr_q;
  assign term = 28'(signed'({1'b0, cmd_i.sel_rev ? rsum_q : fsum_q}))
              + 28'(OffsetAdj) * 28'(signed'({1'b0, count}));
  assign cal = cmd_i.sel_rev ? cal_rev_i : cal_fwd_i;
  assign vprod = 46'(term[18:0]) * 46'(cal) + 46'd128;
  assign vsh = vprod[45:8];

  logic [40:0] sqp;
  logic [44:0] cbp;
  logic [24:0] sqr;
  logic [28:0] cbr;
  assign sqp = 41'(v_q) * 41'(v_q) + 41'd32768;
  assign sqr = sqp[40:16];
  assign cbp = 45'(v2_q) * 45'(v_q) + 45'd32768;
  assign cbr = cbp[44:16];

  logic signed [23:0] mc;
  logic signed [29:0] mv;
  logic signed [54:0] mp;
  always_comb begin
    mc = coef_b_i;
    mv = 30'(v_q);
    if (cmd_i.pc) begin mc = coef_c_i; mv = 30'(v2_q); end
    if (cmd_i.pd) begin mc = coef_d_i; mv = 30'(v3_q); end
  end
  assign mp = 55'(mc) * 55'(mv);

  logic signed [67:0] rnd;
  logic [47:0] pq;
  assign rnd = acc_q + 68'sd524288;
  assign pq = rnd[67:20];
  logic [23:0] pw;
  assign pw = acc_q < 0 ? 24'd0 : (pq > 48'hFFFFFF ? 24'hFFFFFF : pq[23:0]);

  // keep the square and the cube at full width
  logic [24:0] v2w_q;
  logic [28:0] v3w_q;
  assign v2_q = v2w_q;
  assign v3_q = v3w_q;

  // iterative units
  logic [23:0] rem_q;
  logic [31:0] quo_q;
  logic [5:0]  it_q;
  logic [15:0] rho_q;
  logic [33:0] sr_q;
  logic [33:0] srem_q;
  logic [31:0] sx_q;
  logic        valid_q, below_q;
  logic [14:0] swr_q;
  logic [25:0] dsub;
  logic [24:0] rshift;
  assign rshift = {rem_q, 1'b0};
  assign dsub = {1'b0, rshift} - {2'b00, pf_q};
  logic [33:0] strial;
  logic [33:0] srem_n;
  assign srem_n = {srem_q[31:0], sx_q[31:30]};
  assign strial = srem_n - {sr_q[31:0], 2'b01};

  logic [25:0] sden;
  logic [49:0] snum_q;
  logic [25:0] srem2_q;
  logic [26:0] s2;
  assign s2 = {srem2_q, snum_q[49]} - {1'b0, sden};
  assign sden = {9'd0, 17'(17'h10000 - 17'(rho_q))} << 1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.volt) begin
      if (term <= 0) v_q <= '0;
      else v_q <= (vsh > 38'hFFFFF) ? 20'hFFFFF : vsh[19:0];
    end
    if (cmd_i.sq) v2w_q <= sqr;
    if (cmd_i.cube) v3w_q <= cbr;
    if (cmd_i.pa) acc_q <= 68'(coef_a_i) * 68'sd65536;
    if (cmd_i.pb || cmd_i.pc || cmd_i.pd) acc_q <= acc_q + 68'(mp);
    if (cmd_i.pwr) begin
      if (cmd_i.sel_rev) pr_q <= pw;
      else pf_q <= pw;
    end
    if (cmd_i.cmp) begin
      below_q <= pf_q < power_min_i;
      valid_q <= (pf_q > power_min_i) && (pr_q > power_min_i);
      rho_q <= (pr_q >= pf_q) ? RhoMax : 16'd0;
      swr_q <= '0;
    end
    if (cmd_i.div_init) begin
      rem_q <= pr_q;
      quo_q <= '0;
      it_q <= 6'd0;
    end
    if (cmd_i.div_step) begin
      if (!dsub[25]) begin
        rem_q <= dsub[23:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rshift[23:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
      it_q <= it_q + 6'd1;
    end
    if (cmd_i.sqrt_init) begin
      sx_q <= quo_q;
      srem_q <= '0;
      sr_q <= '0;
      it_q <= 6'd0;
    end
    if (cmd_i.sqrt_step) begin
      sx_q <= {sx_q[29:0], 2'b00};
      if (!strial[33]) begin
        srem_q <= strial;
        sr_q <= {sr_q[32:0], 1'b1};
      end else begin
        srem_q <= srem_n;
        sr_q <= {sr_q[32:0], 1'b0};
      end
      it_q <= it_q + 6'd1;
    end
    if (cmd_i.swr_init) begin
      snum_q <= {8'd0, 42'((({25'd0, 17'(17'h10000 + 17'(rho_q))}) << 9) + 42'(sden >> 1))};
      srem2_q <= '0;
      it_q <= 6'd0;
    end
    if (cmd_i.swr_step) begin
      if (!s2[26]) begin
        srem2_q <= s2[25:0];
        snum_q <= {snum_q[48:0], 1'b1};
      end else begin
        srem2_q <= {srem2_q[24:0], snum_q[49]};
        snum_q <= {snum_q[48:0], 1'b0};
      end
      it_q <= it_q + 6'd1;
    end
    if (cmd_i.swr_fin) begin
      if (snum_q[41:0] < 42'(SwrMin)) swr_q <= SwrMin;
      else if (snum_q[41:0] > 42'(SwrMax)) swr_q <= SwrMax;
      else swr_q <= snum_q[14:0];
    end
    if (cmd_i.sqrt_step && it_q == 6'd15) begin
      rho_q <= 16'({sr_q[14:0], ~strial[33]});
    end
  end

  always_comb begin
    sts_o.group_end = (cnt_inc == 8'd0) || (cnt_inc >= count);
    sts_o.valid = (pf_q > power_min_i) && (pr_q > power_min_i);
    sts_o.rho_max = pr_q >= pf_q;
    sts_o.iter_done = (cmd_i.div_step && it_q == 6'd31)
                   || (cmd_i.sqrt_step && it_q == 6'd15)
                   || (cmd_i.swr_step && it_q == 6'd49);
  end

  logic [23:0] o_fp, o_rp;
  logic [15:0] o_rho;
  logic [14:0] o_swr;
  logic        o_below, o_valid;
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      o_fp <= below_q ? 24'd0 : pf_q;
      o_rp <= pr_q;
      o_below <= below_q;
      o_valid <= valid_q;
      o_rho <= valid_q ? rho_q : 16'd0;
      o_swr <= valid_q ? swr_q : 15'd0;
    end
  end
  assign fwd_power_o = o_fp;
  assign rev_power_o = o_rp;
  assign fwd_below_min_o = o_below;
  assign swr_valid_o = o_valid;
  assign reflection_o = o_rho;
  assign swr_value_o = o_swr;
endmodule

// File: rtl/directional_power_swr_meter.sv
// Top level of the directional power and SWR meter: APB registers and wiring.
// Depends on dpsm_pkg, dpsm_ctrl and dpsm_datapath.
// The transfer that ends a group starts a sequenced computation: the
// polynomial for each channel, the compare, the ratio divide, the square root,
// the SWR divide and clamp, and the load of the result. Divide and square root
// are skipped when reverse is not below forward; when no ratio is due, the load
// follows the compare directly. The result loads only once the previous one
// has been taken; no new pair is taken meanwhile.
module directional_power_swr_meter #(
  parameter int unsigned SampleBits = dpsm_pkg::SampleBitsDef,
  parameter int signed   OffsetAdj  = dpsm_pkg::OffsetAdjDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SampleBits-1:0] fwd_sample_i,
  input  logic [SampleBits-1:0] rev_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [23:0]           fwd_power_o,
  output logic [23:0]           rev_power_o,
  output logic                  fwd_below_min_o,
  output logic                  swr_valid_o,
  output logic [15:0]           reflection_o,
  output logic [14:0]           swr_value_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import dpsm_pkg::*;
  logic [7:0]  avg_q;
  logic [23:0] calf_q, calr_q, ca_q, cb_q, cc_q, cd_q, pmin_q;
  reg_idx_e    idx;
  cmd_t        cmd;
  status_t     sts;
  assign idx = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= 8'd2; calf_q <= 24'd24659; calr_q <= 24'd24772;
      ca_q <= 24'd41270; cb_q <= 24'd972202; cc_q <= 24'd960225;
      cd_q <= 24'd119580; pmin_q <= 24'd3277;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegAvg:      avg_q <= pwdata[7:0];
        RegCalFwd:   calf_q <= pwdata[23:0];
        RegCalRev:   calr_q <= pwdata[23:0];
        RegCoefA:    ca_q <= pwdata[23:0];
        RegCoefB:    cb_q <= pwdata[23:0];
        RegCoefC:    cc_q <= pwdata[23:0];
        RegCoefD:    cd_q <= pwdata[23:0];
        RegPowerMin: pmin_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegAvg:      prdata = {24'd0, avg_q};
      RegCalFwd:   prdata = {8'd0, calf_q};
      RegCalRev:   prdata = {8'd0, calr_q};
      RegCoefA:    prdata = {8'd0, ca_q};
      RegCoefB:    prdata = {8'd0, cb_q};
      RegCoefC:    prdata = {8'd0, cc_q};
      RegCoefD:    prdata = {8'd0, cd_q};
      RegPowerMin: prdata = {8'd0, pmin_q};
      default:     prdata = '0;
    endcase
  end

  dpsm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  dpsm_datapath #(.SampleBits(SampleBits), .OffsetAdj(OffsetAdj)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .fwd_sample_i, .rev_sample_i,
    .avg_count_i(avg_q), .cal_fwd_i(calf_q), .cal_rev_i(calr_q),
    .coef_a_i(ca_q), .coef_b_i(cb_q), .coef_c_i(cc_q), .coef_d_i(cd_q),
    .power_min_i(pmin_q),
    .fwd_power_o, .rev_power_o, .fwd_below_min_o, .swr_valid_o,
    .reflection_o, .swr_value_o
  );
endmodule
